FILE: rtl/core/state_observer_feedback_step_macros.svh
// ----------------------------------------------------------------------------
// State observer feedback step: assertion macros
// Shared concurrent assertion forms for the observer RTL.
// ----------------------------------------------------------------------------
`ifndef STATE_OBSERVER_FEEDBACK_STEP_MACROS_SVH
`define STATE_OBSERVER_FEEDBACK_STEP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SOFS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define SOFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

FILE: rtl/core/sofs_pkg.sv
// ----------------------------------------------------------------------------
// sofs_pkg
// Types, coefficient tables and constant helpers for the observer step.
// ----------------------------------------------------------------------------
package sofs_pkg;

  localparam int MAX_ORDER = 8;
  localparam int IDX_MAX_W = 3;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 64;

  // Coefficient ROM layout, rows always eight wide
  localparam int ADDR_W    = 7;
  localparam int ROM_DEPTH = 104;
  localparam int A_BASE    = 0;
  localparam int B_BASE    = 64;
  localparam int C_BASE    = 72;
  localparam int L_BASE    = 80;
  localparam int K_BASE    = 88;
  localparam int X0_BASE   = 96;

  // Pending drive after reset, in tenths
  localparam int DRIVE0_TENTHS = 27;

  // Drain counter width and last count; S_DRAIN waits for the last writeback to land
  localparam int DRAIN_W    = 2;
  localparam int DRAIN_LAST = 2;

  localparam int A_TENTHS [MAX_ORDER][MAX_ORDER] = '{
    '{10, 52, 57, 37, 48, 0, 0, 0},
    '{12, 15, 17, 23, 24, 0, 0, 0},
    '{42, 47, 33, 101, 71, 0, 0, 0},
    '{82, 94, 107, 38, 72, 0, 0, 0},
    '{-103, 123, -473, 840, 940, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0}
  };
  localparam int B_TENTHS  [MAX_ORDER] = '{10, 20, -30, -40, 87, 0, 0, 0};
  localparam int C_TENTHS  [MAX_ORDER] = '{-20, 30, -47, -57, -320, 0, 0, 0};
  localparam int L_TENTHS  [MAX_ORDER] = '{-20, -30, -40, -70, -80, 0, 0, 0};
  localparam int K_TENTHS  [MAX_ORDER] = '{48, 33, 42, 77, 81, 0, 0, 0};
  localparam int X0_TENTHS [MAX_ORDER] = '{10, 29, 38, 47, 56, 0, 0, 0};

  typedef enum logic [1:0] {
    SRC_X,
    SRC_U,
    SRC_ERR
  } src_sel_t;

  typedef enum logic [1:0] {
    DEST_DRIVE,
    DEST_EST,
    DEST_STATE
  } dest_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DRIVE,
    S_EST,
    S_ROW,
    S_DRAIN,
    S_OUT
  } seq_state_t;

  typedef struct packed {
    logic                 first;
    logic                 last;
    dest_sel_t            dest;
    logic [IDX_MAX_W-1:0] row;
  } mac_tag_t;

  typedef struct packed {
    logic                 valid;
    src_sel_t             src;
    logic [IDX_MAX_W-1:0] xidx;
    logic [ADDR_W-1:0]    addr;
    mac_tag_t             tag;
  } issue_t;

  typedef struct packed {
    logic idle;
    logic out_load;
  } seq_status_t;

  typedef struct packed {
    logic                     valid;
    dest_sel_t                dest;
    logic [IDX_MAX_W-1:0]     row;
    logic signed [DATA_W-1:0] value;
  } wb_t;

  // Tenths to fixed point, ties away from zero (elaboration only)
  function automatic logic signed [DATA_W-1:0] to_fixed(input int tenths, input int frac);
    longint mag;
    longint q;
    mag = (tenths < 0) ? -longint'(tenths) : longint'(tenths);
    q   = (mag * (longint'(1) << frac) + 5) / 10;
    return (tenths < 0) ? DATA_W'(-q) : DATA_W'(q);
  endfunction

  // Coefficient in tenths at a ROM address
  function automatic int rom_tenths(input int unsigned addr);
    int unsigned ofs;
    int          val;
    val = 0;
    if (addr < B_BASE) begin
      val = A_TENTHS[addr >> 3][addr & 7];
    end else if (addr < C_BASE) begin
      ofs = addr - B_BASE;
      val = B_TENTHS[ofs];
    end else if (addr < L_BASE) begin
      ofs = addr - C_BASE;
      val = C_TENTHS[ofs];
    end else if (addr < K_BASE) begin
      ofs = addr - L_BASE;
      val = L_TENTHS[ofs];
    end else if (addr < X0_BASE) begin
      ofs = addr - K_BASE;
      val = K_TENTHS[ofs];
    end else if (addr < ROM_DEPTH) begin
      ofs = addr - X0_BASE;
      val = X0_TENTHS[ofs];
    end
    return val;
  endfunction

endpackage

FILE: rtl/core/sofs_coef_rom.sv
// ----------------------------------------------------------------------------
// sofs_coef_rom
// Fixed-point coefficient ROM with registered read data.
// ----------------------------------------------------------------------------
module sofs_coef_rom #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                    clk,
  input  logic [sofs_pkg::ADDR_W-1:0]             addr,
  output logic signed [sofs_pkg::DATA_W-1:0]      data
);

  logic signed [sofs_pkg::DATA_W-1:0] coef_tab [sofs_pkg::ROM_DEPTH];

  for (genvar g = 0; g < sofs_pkg::ROM_DEPTH; g++) begin : g_coef
    assign coef_tab[g] = sofs_pkg::to_fixed(sofs_pkg::rom_tenths(g), FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    data <= coef_tab[addr];
  end

endmodule

FILE: rtl/core/sofs_mac.sv
// ----------------------------------------------------------------------------
// sofs_mac
// Shared multiply, round and accumulate unit with a saturated 32-bit writeback.
// ----------------------------------------------------------------------------
module sofs_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               op_valid,
  input  sofs_pkg::mac_tag_t                 op_tag,
  input  logic signed [sofs_pkg::DATA_W-1:0] op_a,
  input  logic signed [sofs_pkg::DATA_W-1:0] op_b,
  output sofs_pkg::wb_t                      wb
);

  localparam logic signed [sofs_pkg::PROD_W-1:0] ROUND_BIAS =
    sofs_pkg::PROD_W'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [sofs_pkg::PROD_W-1:0] SAT_MAX =
    sofs_pkg::PROD_W'(64'sd2147483647);
  localparam logic signed [sofs_pkg::PROD_W-1:0] SAT_MIN =
    sofs_pkg::PROD_W'(-64'sd2147483648);

  logic signed [sofs_pkg::PROD_W-1:0] prod;
  logic                               prod_valid;
  sofs_pkg::mac_tag_t                 prod_tag;
  logic signed [sofs_pkg::PROD_W-1:0] acc;
  logic signed [sofs_pkg::PROD_W-1:0] rnd;
  logic signed [sofs_pkg::PROD_W-1:0] acc_next;
  logic signed [sofs_pkg::DATA_W-1:0] sat_val;

  always_ff @(posedge clk) begin
    prod     <= op_a * op_b;
    prod_tag <= op_tag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= op_valid;
    end
  end

  // Round to FRAC_BITS (floor after bias), then add into the running sum
  always_comb begin
    rnd      = (prod + ROUND_BIAS) >>> FRAC_BITS;
    acc_next = (prod_tag.first ? '0 : acc) + rnd;
    if (acc_next > SAT_MAX) begin
      sat_val = SAT_MAX[sofs_pkg::DATA_W-1:0];
    end else if (acc_next < SAT_MIN) begin
      sat_val = SAT_MIN[sofs_pkg::DATA_W-1:0];
    end else begin
      sat_val = acc_next[sofs_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (prod_valid) begin
      acc <= acc_next;
    end
    wb.dest  <= prod_tag.dest;
    wb.row   <= prod_tag.row;
    wb.value <= sat_val;
    if (rst) begin
      wb.valid <= 1'b0;
    end else begin
      wb.valid <= prod_valid && prod_tag.last;
    end
  end

endmodule

FILE: rtl/core/sofs_seq.sv
// ----------------------------------------------------------------------------
// sofs_seq
// Sequencer: issues drive, estimate and state-row MAC ops one per cycle.
// ----------------------------------------------------------------------------
module sofs_seq #(
  parameter int ORDER_USED = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  out_free,
  output sofs_pkg::issue_t      issue,
  output sofs_pkg::seq_status_t status
);

  localparam int IDX_W  = (ORDER_USED > 1) ? $clog2(ORDER_USED) : 1;
  localparam int TERM_W = $clog2(ORDER_USED + 2);

  sofs_pkg::seq_state_t          state;
  sofs_pkg::seq_state_t          state_next;
  logic [TERM_W-1:0]             term;
  logic [IDX_W-1:0]              row;
  logic [sofs_pkg::DRAIN_W-1:0]  drain;
  logic [TERM_W-1:0]             col;
  logic [sofs_pkg::IDX_MAX_W-1:0] col3;
  logic [sofs_pkg::IDX_MAX_W-1:0] row3;
  logic                          term_last;
  logic                          row_last;

  always_comb begin
    col  = term - TERM_W'(2);
    col3 = sofs_pkg::IDX_MAX_W'(col);
    row3 = sofs_pkg::IDX_MAX_W'(row);
    row_last = (row == IDX_W'(ORDER_USED - 1));
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      sofs_pkg::S_IDLE:  if (start) state_next = sofs_pkg::S_DRIVE;
      sofs_pkg::S_DRIVE: if (term_last) state_next = sofs_pkg::S_EST;
      sofs_pkg::S_EST:   if (term_last) state_next = sofs_pkg::S_ROW;
      sofs_pkg::S_ROW:   if (term_last && row_last) state_next = sofs_pkg::S_DRAIN;
      sofs_pkg::S_DRAIN: begin
        if (drain == sofs_pkg::DRAIN_W'(sofs_pkg::DRAIN_LAST)) begin
          state_next = sofs_pkg::S_OUT;
        end
      end
      sofs_pkg::S_OUT:   if (out_free) state_next = sofs_pkg::S_IDLE;
      default:           state_next = sofs_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    issue           = '0;
    issue.src       = sofs_pkg::SRC_X;
    issue.tag.dest  = sofs_pkg::DEST_DRIVE;
    term_last       = 1'b0;
    status.idle     = 1'b0;
    status.out_load = 1'b0;
    unique case (state)
      sofs_pkg::S_IDLE: begin
        status.idle = 1'b1;
      end
      sofs_pkg::S_DRIVE, sofs_pkg::S_EST: begin
        term_last       = (term == TERM_W'(ORDER_USED - 1));
        issue.valid     = 1'b1;
        issue.src       = sofs_pkg::SRC_X;
        issue.xidx      = sofs_pkg::IDX_MAX_W'(term);
        issue.tag.first = (term == '0);
        issue.tag.last  = term_last;
        if (state == sofs_pkg::S_DRIVE) begin
          issue.addr     = sofs_pkg::ADDR_W'(sofs_pkg::K_BASE) + sofs_pkg::ADDR_W'(term);
          issue.tag.dest = sofs_pkg::DEST_DRIVE;
        end else begin
          issue.addr     = sofs_pkg::ADDR_W'(sofs_pkg::C_BASE) + sofs_pkg::ADDR_W'(term);
          issue.tag.dest = sofs_pkg::DEST_EST;
        end
      end
      sofs_pkg::S_ROW: begin
        // term 0: B*u, term 1: L*err, then A row against x
        term_last       = (term == TERM_W'(ORDER_USED + 1));
        issue.valid     = 1'b1;
        issue.tag.first = (term == '0);
        issue.tag.last  = term_last;
        issue.tag.dest  = sofs_pkg::DEST_STATE;
        issue.tag.row   = row3;
        if (term == TERM_W'(0)) begin
          issue.src  = sofs_pkg::SRC_U;
          issue.addr = sofs_pkg::ADDR_W'(sofs_pkg::B_BASE) + sofs_pkg::ADDR_W'(row);
        end else if (term == TERM_W'(1)) begin
          issue.src  = sofs_pkg::SRC_ERR;
          issue.addr = sofs_pkg::ADDR_W'(sofs_pkg::L_BASE) + sofs_pkg::ADDR_W'(row);
        end else begin
          issue.src  = sofs_pkg::SRC_X;
          issue.xidx = col3;
          issue.addr = sofs_pkg::ADDR_W'(sofs_pkg::A_BASE) + sofs_pkg::ADDR_W'({row3, col3});
        end
      end
      sofs_pkg::S_DRAIN: begin
      end
      sofs_pkg::S_OUT: begin
        status.out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sofs_pkg::S_IDLE;
      term  <= '0;
      row   <= '0;
      drain <= '0;
    end else begin
      state <= state_next;
      case (state)
        sofs_pkg::S_IDLE: begin
          term  <= '0;
          row   <= '0;
          drain <= '0;
        end
        sofs_pkg::S_DRIVE, sofs_pkg::S_EST: begin
          term <= term_last ? '0 : term + TERM_W'(1);
        end
        sofs_pkg::S_ROW: begin
          if (term_last) begin
            term <= '0;
            row  <= row + IDX_W'(1);
          end else begin
            term <= term + TERM_W'(1);
          end
        end
        sofs_pkg::S_DRAIN: begin
          drain <= drain + sofs_pkg::DRAIN_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/state_observer_feedback_step.sv
// ----------------------------------------------------------------------------
// state_observer_feedback_step
// Observer with state feedback, one control step per measured sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel meas_valid/meas_ready carries one measured_output sample
//   (signed fixed point). Result channel result_valid/result_ready carries
//   drive_value (K.x), output_estimate (C.x) and estimate_error (measurement
//   minus the previous estimate), all saturated to 32 bits.
//   Every product goes through one shared 32x32 multiplier with a rounding
//   accumulator; a small sequencer issues one MAC op per cycle:
//   N drive terms, N estimate terms and N rows of N+2 terms, N = order.
//   After its MAC ops a step drains the last writeback, then loads the
//   result into the output register once that register is free.
//   meas_ready is low while a step is in progress.
//   The result sits in an output register: a new sample may be accepted
//   while it waits. If the receiver stalls, the next step completes its
//   arithmetic and then holds until the output register frees.
//   Reset (synchronous, active high) loads the initial state vector and
//   pending drive, clears the previous estimate and empties the output.
// ----------------------------------------------------------------------------
`include "state_observer_feedback_step_macros.svh"

module state_observer_feedback_step #(
  parameter int STATE_ORDER = 5,
  parameter int FRAC_BITS   = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               meas_valid,
  output logic                               meas_ready,
  input  logic signed [sofs_pkg::DATA_W-1:0] measured_output,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic signed [sofs_pkg::DATA_W-1:0] drive_value,
  output logic signed [sofs_pkg::DATA_W-1:0] output_estimate,
  output logic signed [sofs_pkg::DATA_W-1:0] estimate_error
);

  localparam int ORDER_USED = (STATE_ORDER < 1) ? 1 :
                              ((STATE_ORDER > sofs_pkg::MAX_ORDER) ?
                               sofs_pkg::MAX_ORDER : STATE_ORDER);
  localparam int IDX_W = (ORDER_USED > 1) ? $clog2(ORDER_USED) : 1;
  localparam logic signed [sofs_pkg::DATA_W-1:0] DRIVE_RST =
    sofs_pkg::to_fixed(sofs_pkg::DRIVE0_TENTHS, FRAC_BITS);

  logic signed [sofs_pkg::DATA_W-1:0] state_vec [ORDER_USED];
  logic signed [sofs_pkg::DATA_W-1:0] state_rst [ORDER_USED];
  logic signed [sofs_pkg::DATA_W-1:0] x_cur [ORDER_USED];
  logic signed [sofs_pkg::DATA_W-1:0] u_cur;
  logic signed [sofs_pkg::DATA_W-1:0] err_cur;
  logic signed [sofs_pkg::DATA_W-1:0] err_next;
  logic signed [sofs_pkg::DATA_W:0]   diff;
  logic signed [sofs_pkg::DATA_W-1:0] pending_drive;
  logic signed [sofs_pkg::DATA_W-1:0] previous_estimate;

  logic signed [sofs_pkg::DATA_W-1:0] operand;
  logic signed [sofs_pkg::DATA_W-1:0] operand_next;
  logic signed [sofs_pkg::DATA_W-1:0] coef;
  sofs_pkg::mac_tag_t                 op_tag;
  logic                               op_valid;

  sofs_pkg::issue_t      issue;
  sofs_pkg::seq_status_t status;
  sofs_pkg::wb_t         wb;
  logic                  meas_take;
  logic                  out_free;

  for (genvar g = 0; g < ORDER_USED; g++) begin : g_rst
    assign state_rst[g] = sofs_pkg::to_fixed(
      sofs_pkg::rom_tenths(sofs_pkg::X0_BASE + g), FRAC_BITS);
  end

  assign meas_ready = status.idle;
  assign meas_take  = meas_valid && meas_ready;
  assign out_free   = !result_valid || result_ready;

  sofs_seq #(
    .ORDER_USED (ORDER_USED)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (meas_take),
    .out_free (out_free),
    .issue    (issue),
    .status   (status)
  );

  sofs_coef_rom #(
    .FRAC_BITS (FRAC_BITS)
  ) u_rom (
    .clk  (clk),
    .addr (issue.addr),
    .data (coef)
  );

  sofs_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op_tag   (op_tag),
    .op_a     (operand),
    .op_b     (coef),
    .wb       (wb)
  );

  // Error against the estimate left by the previous step, saturated
  always_comb begin
    diff = {measured_output[sofs_pkg::DATA_W-1], measured_output}
         - {previous_estimate[sofs_pkg::DATA_W-1], previous_estimate};
    if (diff[sofs_pkg::DATA_W] != diff[sofs_pkg::DATA_W-1]) begin
      err_next = diff[sofs_pkg::DATA_W] ? {1'b1, {(sofs_pkg::DATA_W-1){1'b0}}}
                                        : {1'b0, {(sofs_pkg::DATA_W-1){1'b1}}};
    end else begin
      err_next = diff[sofs_pkg::DATA_W-1:0];
    end
  end

  always_comb begin
    case (issue.src)
      sofs_pkg::SRC_U:   operand_next = u_cur;
      sofs_pkg::SRC_ERR: operand_next = err_cur;
      default:           operand_next = x_cur[issue.xidx[IDX_W-1:0]];
    endcase
  end

  // Snapshot of the step's inputs
  always_ff @(posedge clk) begin
    if (meas_take) begin
      x_cur   <= state_vec;
      u_cur   <= pending_drive;
      err_cur <= err_next;
    end
  end

  // Operand stage, lines up with the registered ROM read
  always_ff @(posedge clk) begin
    operand <= operand_next;
    op_tag  <= issue.tag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else begin
      op_valid <= issue.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state_vec         <= state_rst;
      pending_drive     <= DRIVE_RST;
      previous_estimate <= '0;
    end else if (wb.valid) begin
      case (wb.dest)
        sofs_pkg::DEST_DRIVE: pending_drive     <= wb.value;
        sofs_pkg::DEST_EST:   previous_estimate <= wb.value;
        default:              state_vec[wb.row[IDX_W-1:0]] <= wb.value;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (status.out_load) begin
      drive_value     <= pending_drive;
      output_estimate <= previous_estimate;
      estimate_error  <= err_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (status.out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  `SOFS_ASSERT_NOW(a_idle_no_issue, clk, rst, meas_ready, !issue.valid)
  `SOFS_ASSERT_NOW(a_idle_no_wb, clk, rst, meas_ready, !wb.valid && !op_valid)
  `SOFS_ASSERT_NOW(a_load_slot_free, clk, rst, status.out_load, out_free)
  `SOFS_ASSERT_NEXT(a_start_first_op, clk, rst, meas_take,
                    issue.valid && issue.tag.first && !meas_ready)

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: observer step with state feedback
// Feeds measured samples through a valid/ready channel and checks the drive,
// estimate and estimate error of every step against an in-bench fixed-point
// model of the fifth-order observer, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     ORDER        = 5;
  localparam int     FRAC         = 16;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     DRAIN_CYCLES = 200;
  localparam int     STALL_LIMIT  = 4000;
  localparam int     RANDOM_ITEMS = 1600;
  localparam longint Q_MAX        = 64'sd2147483647;
  localparam longint Q_MIN        = -64'sd2147483648;

  // coefficients in tenths
  localparam int A_TENTHS [ORDER][ORDER] = '{
    '{10, 52, 57, 37, 48},
    '{12, 15, 17, 23, 24},
    '{42, 47, 33, 101, 71},
    '{82, 94, 107, 38, 72},
    '{-103, 123, -473, 840, 940}
  };
  localparam int B_TENTHS  [ORDER] = '{10, 20, -30, -40, 87};
  localparam int C_TENTHS  [ORDER] = '{-20, 30, -47, -57, -320};
  localparam int L_TENTHS  [ORDER] = '{-20, -30, -40, -70, -80};
  localparam int K_TENTHS  [ORDER] = '{48, 33, 42, 77, 81};
  localparam int X0_TENTHS [ORDER] = '{10, 29, 38, 47, 56};
  localparam int DRIVE0_TENTHS     = 27;

  typedef struct {
    logic signed [31:0] drive;
    logic signed [31:0] estimate;
    logic signed [31:0] error;
  } step_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               meas_valid = 1'b0;
  logic               meas_ready;
  logic signed [31:0] measured_output = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  logic signed [31:0] drive_value;
  logic signed [31:0] output_estimate;
  logic signed [31:0] estimate_error;

  state_observer_feedback_step uut (
    .clk             (clk),
    .rst             (rst),
    .meas_valid      (meas_valid),
    .meas_ready      (meas_ready),
    .measured_output (measured_output),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .drive_value     (drive_value),
    .output_estimate (output_estimate),
    .estimate_error  (estimate_error)
  );

  // observer state as the predictor sees it
  logic signed [31:0] state_vec [ORDER];
  logic signed [31:0] applied_drive;
  logic signed [31:0] last_estimate;

  logic signed [31:0] pending_samples [$];
  step_result_t       expected_steps [$];

  int  samples_taken = 0;
  int  steps_checked = 0;
  int  fail_count    = 0;
  int  sat_drive     = 0;
  int  sat_estimate  = 0;
  int  sat_error     = 0;
  int  sat_state     = 0;
  int  idle_cycles   = 0;
  int  hold_left     = 0;
  bit  hold_done     = 1'b0;
  bit  meas_fire     = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic signed [31:0] tenths_to_q(input int tenths);
    longint mag;
    longint q;
    mag = (tenths < 0) ? -longint'(tenths) : longint'(tenths);
    q   = (mag * (longint'(1) << FRAC) + 5) / 10;
    if (tenths < 0) q = -q;
    return q[31:0];
  endfunction

  // exact product, rounded half up to FRAC fractional bits
  function automatic longint round_mul(input logic signed [31:0] a, input int tenths);
    longint p;
    p = longint'(a) * longint'(tenths_to_q(tenths));
    p = p + (longint'(1) << (FRAC - 1));
    return p >>> FRAC;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v, inout int hits);
    if (v > Q_MAX) begin
      hits++;
      return 32'sh7fffffff;
    end
    if (v < Q_MIN) begin
      hits++;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  task automatic observer_step(input logic signed [31:0] meas);
    logic signed [31:0] x [ORDER];
    logic signed [31:0] u;
    longint             acc_d;
    longint             acc_e;
    longint             acc;
    step_result_t       r;
    acc_d = 0;
    acc_e = 0;
    u = applied_drive;
    for (int i = 0; i < ORDER; i++) begin
      x[i] = state_vec[i];
      acc_d += round_mul(x[i], K_TENTHS[i]);
      acc_e += round_mul(x[i], C_TENTHS[i]);
    end
    r.drive    = clamp32(acc_d, sat_drive);
    r.estimate = clamp32(acc_e, sat_estimate);
    r.error    = clamp32(longint'(meas) - longint'(last_estimate), sat_error);
    for (int i = 0; i < ORDER; i++) begin
      acc = round_mul(u, B_TENTHS[i]) + round_mul(r.error, L_TENTHS[i]);
      for (int j = 0; j < ORDER; j++) acc += round_mul(x[j], A_TENTHS[i][j]);
      state_vec[i] = clamp32(acc, sat_state);
    end
    applied_drive = r.drive;
    last_estimate = r.estimate;
    expected_steps.push_back(r);
  endtask

  function automatic logic signed [31:0] random_sample();
    int                 pick;
    logic signed [31:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      v = $urandom();
    end else if (pick < 65) begin
      v = int'($urandom_range(0, 2097152)) - 1048576;
    end else if (pick < 80) begin
      if ($urandom_range(0, 1)) v = 32'sh7fffffff - $urandom_range(0, 255);
      else v = 32'sh80000000 + $urandom_range(0, 255);
    end else if (pick < 90) begin
      case ($urandom_range(0, 4))
        0: v = 32'sh7fffffff;
        1: v = 32'sh80000000;
        2: v = -1;
        3: v = 1;
        default: v = 0;
      endcase
    end else begin
      v = (int'($urandom_range(0, 200)) - 100) <<< FRAC;
    end
    return v;
  endfunction

  function automatic void report(input string field, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
    fail_count++;
    $error("%s mismatch: expected %0d, got %0d", field, want, got);
  endfunction

  // acceptance on both channels, prediction and checking
  always @(posedge clk) begin
    step_result_t e;
    meas_fire = !rst && meas_valid && meas_ready;
    if (meas_fire) begin
      observer_step(measured_output);
      samples_taken++;
    end
    if (!rst && result_valid && result_ready) begin
      steps_checked++;
      if (expected_steps.size() == 0) begin
        fail_count++;
        $error("result item with nothing expected");
      end else begin
        e = expected_steps.pop_front();
        if (drive_value !== e.drive) report("drive_value", e.drive, drive_value);
        if (output_estimate !== e.estimate)
          report("output_estimate", e.estimate, output_estimate);
        if (estimate_error !== e.error) report("estimate_error", e.error, estimate_error);
      end
    end
  end

  // sample driver
  always @(negedge clk) begin
    bit quiet;
    quiet = (samples_taken >= 700 && samples_taken < 1000);
    if (rst) begin
      meas_valid <= 1'b0;
    end else if (!meas_valid || meas_fire) begin
      if (pending_samples.size() != 0 && (quiet || $urandom_range(0, 99) >= 14)) begin
        meas_valid      <= 1'b1;
        measured_output <= pending_samples.pop_front();
      end else begin
        meas_valid <= 1'b0;
      end
    end
  end

  // result receiver; one long hold-off lets the block back up onto its input
  always @(negedge clk) begin
    bit quiet;
    quiet = (steps_checked >= 1000 && steps_checked < 1300);
    if (!hold_done && steps_checked >= 300) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= quiet || ($urandom_range(0, 99) >= 14);
    end
  end

  always @(posedge clk) begin
    if (rst || (meas_valid && meas_ready) || (result_valid && result_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < ORDER; i++) state_vec[i] = tenths_to_q(X0_TENTHS[i]);
    applied_drive = tenths_to_q(DRIVE0_TENTHS);
    last_estimate = '0;

    // extremes, sign flips and error saturation in both directions
    pending_samples.push_back(32'sh00000000);
    pending_samples.push_back(32'sh00000001);
    pending_samples.push_back(-32'sh00000001);
    pending_samples.push_back(32'sh00010000);
    pending_samples.push_back(-32'sh00010000);
    pending_samples.push_back(32'sh7fffffff);
    pending_samples.push_back(32'sh80000000);
    pending_samples.push_back(32'sh7fffffff);
    pending_samples.push_back(32'sh80000000);
    pending_samples.push_back(32'sh55555555);
    pending_samples.push_back(32'shaaaaaaaa);
    pending_samples.push_back(32'sh40000000);
    pending_samples.push_back(-32'sh40000000);
    pending_samples.push_back(32'sh00008000);
    pending_samples.push_back(32'sh80000001);
    pending_samples.push_back(32'sh7ffffffe);
    pending_samples.push_back(32'sh00000000);
    pending_samples.push_back(32'sh00000000);
    for (int i = 0; i < RANDOM_ITEMS; i++) pending_samples.push_back(random_sample());

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_samples.size() != 0 || meas_valid) @(posedge clk);
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d samples, %0d steps checked, %0d mismatches",
             samples_taken, steps_checked, fail_count);
    $display("Saturated sums: drive %0d, estimate %0d, error %0d, state %0d",
             sat_drive, sat_estimate, sat_error, sat_state);
    if (fail_count == 0 && expected_steps.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
